### src/float_add_sub_macros.svh
// Assertion macros used by float_add_sub.sv.
`ifndef FLOAT_ADD_SUB_MACROS_SVH
`define FLOAT_ADD_SUB_MACROS_SVH

// A condition that must hold at every clock edge outside reset.
`define FAS_ASSERT_ALWAYS(label, clk, rst, cond, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (cond)) else $error(msg);

// An antecedent that implies a consequent in the following cycle.
`define FAS_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

### src/fas_pkg.sv
`timescale 1ns / 1ps
package fas_pkg;
   localparam int TotalBitsDefault    = 32;
   localparam int FractionBitsDefault = 23;

   typedef enum logic {
      OP_ADD = 1'b0,
      OP_SUB = 1'b1
   } opcode_type;
endpackage

### src/fas_core.sv
`timescale 1ns / 1ps
// Combinational add path: unpack, order, align, add, normalize, round, then NaN, infinity and zero cases.
module fas_core #(
   parameter int TOTAL_BITS    = fas_pkg::TotalBitsDefault,
   parameter int FRACTION_BITS = fas_pkg::FractionBitsDefault
) (
   input  logic [TOTAL_BITS-1:0] a,
   input  logic [TOTAL_BITS-1:0] b,
   output logic [TOTAL_BITS-1:0] y
);
   localparam int EW = TOTAL_BITS - 1 - FRACTION_BITS;
   localparam int MW = FRACTION_BITS + 1;
   localparam int SW = MW + 3;              // significand with guard, round, sticky
   localparam int XW = EW + 2;              // unsigned working exponent
   localparam int DW = $clog2(SW + 1) + 1;  // normalization shift count
   localparam logic [EW-1:0] EXP_ALL = {EW{1'b1}};
   localparam logic [TOTAL_BITS-1:0] QNAN =
      {1'b0, EXP_ALL, 1'b1, {(FRACTION_BITS-1){1'b0}}};

   logic            sa, sb, s_big, s_small;
   logic [EW-1:0]   ea, eb;
   logic [FRACTION_BITS-1:0] fa, fb;
   logic [MW-1:0]   ma, mb, m_big, m_small;
   logic [EW-1:0]   xa, xb, x_big, x_small;
   logic            swap;
   logic [EW-1:0]   diff;
   logic [SW-1:0]   big_ext, small_ext, small_al, lost_mask;
   logic [SW:0]     sum;
   logic [SW-1:0]   s1, s2;
   logic [XW-1:0]   e1, e2, e3;
   logic [DW-1:0]   lz, sh;
   logic            lz_found;
   logic [2:0]      grs;
   logic [MW:0]     keep;
   logic            is_nan_a, is_nan_b, is_inf_a, is_inf_b;

   always_comb begin
      sa = a[TOTAL_BITS-1];
      sb = b[TOTAL_BITS-1];
      ea = a[TOTAL_BITS-2:FRACTION_BITS];
      eb = b[TOTAL_BITS-2:FRACTION_BITS];
      fa = a[FRACTION_BITS-1:0];
      fb = b[FRACTION_BITS-1:0];
      is_nan_a = (ea == EXP_ALL) && (fa != '0);
      is_nan_b = (eb == EXP_ALL) && (fb != '0);
      is_inf_a = (ea == EXP_ALL) && (fa == '0);
      is_inf_b = (eb == EXP_ALL) && (fb == '0);
      ma = {(ea != '0), fa};
      mb = {(eb != '0), fb};
      xa = (ea == '0) ? EW'(1) : ea;
      xb = (eb == '0) ? EW'(1) : eb;
      swap = (xb > xa) || ((xb == xa) && (mb > ma));
      m_big   = swap ? mb : ma;
      m_small = swap ? ma : mb;
      s_big   = swap ? sb : sa;
      s_small = swap ? sa : sb;
      x_big   = swap ? xb : xa;
      x_small = swap ? xa : xb;
      diff = x_big - x_small;
      big_ext   = {m_big, 3'b000};
      small_ext = {m_small, 3'b000};
      // Bits shifted out of the smaller operand fold into the sticky bit.
      if (diff >= EW'(SW)) begin
         small_al = {{(SW-1){1'b0}}, (small_ext != '0)};
      end else begin
         lost_mask = ~({SW{1'b1}} << diff);
         small_al  = (small_ext >> diff) | SW'((small_ext & lost_mask) != '0);
      end
      if (diff < EW'(SW)) lost_mask = ~({SW{1'b1}} << diff);
      else lost_mask = '1;

      e1 = XW'(x_big);
      if (s_big == s_small) begin
         sum = {1'b0, big_ext} + {1'b0, small_al};
      end else begin
         sum = {1'b0, big_ext} - {1'b0, small_al};
      end
      // Leading-zero count over the sum or difference.
      lz = DW'(SW);
      lz_found = 1'b0;
      for (int i = SW - 1; i >= 0; i--) begin
         if (!lz_found && sum[i]) begin
            lz = DW'(SW - 1 - i);
            lz_found = 1'b1;
         end
      end
      if (sum[SW]) begin
         s1 = sum[SW:1] | SW'(sum[0]);
         e2 = e1 + XW'(1);
         sh = '0;
      end else begin
         // Shift left no further than exponent 1 allows.
         if (XW'(lz) > e1 - XW'(1)) sh = DW'(e1 - XW'(1));
         else sh = lz;
         s1 = sum[SW-1:0];
         e2 = e1 - XW'(sh);
      end
      s2  = s1 << sh;
      grs = s2[2:0];
      keep = {1'b0, s2[SW-1:3]};
      if ((grs > 3'd4) || ((grs == 3'd4) && keep[0])) keep = keep + 1'b1;
      e3 = e2;
      if (keep[MW]) begin
         keep = keep >> 1;
         e3 = e2 + XW'(1);
      end

      if (is_nan_a || is_nan_b) y = QNAN;
      else if (is_inf_a) y = (is_inf_b && (sa != sb)) ? QNAN : a;
      else if (is_inf_b) y = b;
      else if ((s_big != s_small) && (sum == '0)) y = '0;
      else if (e3 >= XW'(EXP_ALL)) y = {s_big, EXP_ALL, {FRACTION_BITS{1'b0}}};
      else y = {s_big, {(TOTAL_BITS-1){1'b0}}}
               | ((TOTAL_BITS'(EW'(e3 - XW'(1))) << FRACTION_BITS)
                  + TOTAL_BITS'(keep));
   end
endmodule

### src/float_add_sub.sv
`timescale 1ns / 1ps
// Channel   Words                          Handshake
// req       tdata={operand_b,operand_a}    req_tvalid/req_tready
//           tuser=opcode
// rsp       tdata=sum_bits                 rsp_tvalid/rsp_tready
// One word per cycle while the result is not stalled; the word passes an input register, then a result register.
// Reset is synchronous and clears the valid flags only.
// A stalled result holds; the input stage still loads while the result stage empties.
`include "float_add_sub_macros.svh"
module float_add_sub #(
   parameter int TOTAL_BITS    = fas_pkg::TotalBitsDefault,
   parameter int FRACTION_BITS = fas_pkg::FractionBitsDefault
) (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    req_tvalid,
   output logic                    req_tready,
   input  logic [2*TOTAL_BITS-1:0] req_tdata,  // operand_a, operand_b
   input  logic                    req_tuser,  // opcode
   output logic                    rsp_tvalid,
   input  logic                    rsp_tready,
   output logic [TOTAL_BITS-1:0]   rsp_tdata   // sum_bits
);
   logic                  in_vld_ff, out_vld_ff;
   logic [TOTAL_BITS-1:0] a_ff, b_ff, a_in, b_in, sum_in, sum_ff;
   logic                  out_adv, in_adv;

   assign out_adv    = in_vld_ff && (!out_vld_ff || rsp_tready);
   assign req_tready = !in_vld_ff || out_adv;
   assign in_adv     = req_tvalid && req_tready;

   always_comb begin
      a_in = req_tdata[TOTAL_BITS-1:0];
      b_in = req_tdata[2*TOTAL_BITS-1:TOTAL_BITS];
      if (fas_pkg::opcode_type'(req_tuser) == fas_pkg::OP_SUB)
         b_in[TOTAL_BITS-1] = ~b_in[TOTAL_BITS-1];
   end

   fas_core #(.TOTAL_BITS(TOTAL_BITS), .FRACTION_BITS(FRACTION_BITS)) u_core (
      .a(a_ff), .b(b_ff), .y(sum_in)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         in_vld_ff  <= 1'b0;
         out_vld_ff <= 1'b0;
      end else begin
         if (req_tready) in_vld_ff <= req_tvalid;
         if (out_adv) out_vld_ff <= 1'b1;
         else if (rsp_tready) out_vld_ff <= 1'b0;
      end
      if (in_adv) begin
         a_ff <= a_in;
         b_ff <= b_in;
      end
      if (out_adv) sum_ff <= sum_in;
   end

   assign rsp_tvalid = out_vld_ff;
   assign rsp_tdata  = sum_ff;

   `FAS_ASSERT_NEXT(a_stall_hold, clock, reset, rsp_tvalid && !rsp_tready, rsp_tvalid && $stable(rsp_tdata), "result changed while stalled")
   `FAS_ASSERT_NEXT(a_load_out, clock, reset, out_adv, rsp_tvalid, "result lost")
   `FAS_ASSERT_ALWAYS(a_no_drop, clock, reset, !(in_vld_ff && !req_tready && !(out_vld_ff && !rsp_tready)), "input stage blocked without cause")
endmodule
